// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tachometer RTL. Each form uses
// the clk and rst_n of the module that expands it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define TACH_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define TACH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tach_pkg.sv
// ----------------------------------------------------------------------------
// Tachometer package
// Shared sizes, constants, register indexes and types of the engine speed
// tachometer.
// ----------------------------------------------------------------------------
package tach_pkg;

    // Period ring geometry
    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W      = 16 + $clog2(RING_DEPTH);
    localparam int BAD_W      = $clog2(RING_DEPTH + 1);

    // Serial divider geometry
    localparam int DIV_W      = 24;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    // Period and counter constants
    localparam logic [15:0] INVALID_MARK   = 16'hffff;
    localparam logic [15:0] MIN_PERIOD     = 16'd100;
    localparam logic [4:0]  COUNTDOWN_FULL = 5'd16;
    localparam logic [7:0]  WRAP_AT        = 8'd250;
    localparam logic [7:0]  WRAP_TO        = 8'd4;
    localparam logic [15:0] SPEED_MAX      = 16'hffff;

    // Register reset values
    localparam logic [23:0] RST_SPEED_CONSTANT = 24'd8421000;
    localparam logic [15:0] RST_MAX_AVG_PERIOD = 16'd62330;
    localparam logic [15:0] RST_LEVEL_LOW      = 16'd500;
    localparam logic [15:0] RST_LEVEL_MID      = 16'd1450;
    localparam logic [15:0] RST_LEVEL_HIGH     = 16'd1750;
    localparam logic [15:0] RST_HYSTERESIS     = 16'd100;
    localparam logic [7:0]  RST_INVALID_LIMIT  = 8'd10;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_CONSTANT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_AVG_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_LOW      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_MID      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_HIGH     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVALID_LIMIT  = 3'd6;

    // Input command codes
    localparam logic CMD_CAPTURE  = 1'b0;
    localparam logic CMD_OVERFLOW = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_SPD_START,
        ST_SPD_WAIT,
        ST_DONE
    } tach_state_t;

    // Ring control from the sequencer
    typedef struct packed {
        logic load;
        logic commit;
    } ring_ctrl_t;

    // Divider status to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/engine_speed_tachometer_top.sv
// Sequence: an accepted item passes READ, WRITE, AVG_START and AVG_WAIT (average division),
// then SPD_START and SPD_WAIT (speed division) unless the ring is bad, the timer stale or
// the average above the limit, and DONE, which commits the result once the output is free.
// Throughput: one item at a time, accepted only in idle; the block takes no new item until
// the last one has passed DONE. An item may be accepted while the previous result waits on the output.
// Reset (rst_n low, asynchronous): ring empty, registers at their defaults,
// relays and counters cleared, output empty.
// ----------------------------------------------------------------------------
// Engine speed tachometer
// Averages capture periods over a ring, divides a speed constant by the
// average with a bit-serial divider and drives three hysteresis relays.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module engine_speed_tachometer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [15:0]                       capture_time,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [15:0]                       speed,
    output logic                              relay_low,
    output logic                              relay_mid,
    output logic                              relay_high,
    output logic                              ring_invalid,
    input  logic                              cfg_we,
    input  logic [tach_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tach_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers
    logic [23:0] speed_constant_reg;
    logic [15:0] max_avg_period_reg;
    logic [15:0] level_low_reg;
    logic [15:0] level_mid_reg;
    logic [15:0] level_high_reg;
    logic [15:0] hysteresis_reg;
    logic [7:0]  invalid_limit_reg;

    // Item state
    tach_pkg::tach_state_t  state_reg;
    tach_pkg::tach_state_t  state_next;
    logic [15:0]            prev_capture_reg;
    logic [4:0]             countdown_reg;
    logic                   stale_reg;
    logic [15:0]            period_reg;
    logic                   store_reg;
    logic [15:0]            avg_reg;
    logic [7:0]             invalid_count_reg;
    logic [7:0]             invalid_count_next;
    logic [15:0]            held_speed_reg;
    logic [15:0]            held_speed_next;
    logic [2:0]             relay_reg;
    logic [2:0]             relay_next;

    // Output register
    logic                   out_valid_reg;
    logic [15:0]            speed_reg;
    logic [2:0]             relay_out_reg;
    logic                   ring_invalid_reg;

    // Interconnect
    tach_pkg::ring_ctrl_t            ring_ctrl;
    tach_pkg::div_status_t           div_status;
    logic [tach_pkg::SUM_W-1:0]      ring_sum;
    logic                            ring_bad;
    logic                            div_start;
    logic [tach_pkg::DIV_W-1:0]      div_dividend;
    logic [tach_pkg::DIVISOR_W-1:0]  div_divisor;
    logic [tach_pkg::DIV_CNT_W-1:0]  div_steps;
    logic [tach_pkg::DIV_W-1:0]      div_quotient;
    logic                            accept;
    logic                            commit;
    logic                            out_free;
    logic                            capture_ok;
    logic [15:0]                     new_period;
    logic [15:0]                     speed_sat;
    logic [7:0]                      count_inc;
    logic [15:0]                     levels [3];

    tach_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ring_ctrl),
        .wr_data (period_reg),
        .sum     (ring_sum),
        .bad     (ring_bad)
    );

    tach_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_constant_reg <= tach_pkg::RST_SPEED_CONSTANT;
            max_avg_period_reg <= tach_pkg::RST_MAX_AVG_PERIOD;
            level_low_reg      <= tach_pkg::RST_LEVEL_LOW;
            level_mid_reg      <= tach_pkg::RST_LEVEL_MID;
            level_high_reg     <= tach_pkg::RST_LEVEL_HIGH;
            hysteresis_reg     <= tach_pkg::RST_HYSTERESIS;
            invalid_limit_reg  <= tach_pkg::RST_INVALID_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tach_pkg::CFG_SPEED_CONSTANT: speed_constant_reg <= cfg_data;
                tach_pkg::CFG_MAX_AVG_PERIOD: max_avg_period_reg <= cfg_data[15:0];
                tach_pkg::CFG_LEVEL_LOW:      level_low_reg      <= cfg_data[15:0];
                tach_pkg::CFG_LEVEL_MID:      level_mid_reg      <= cfg_data[15:0];
                tach_pkg::CFG_LEVEL_HIGH:     level_high_reg     <= cfg_data[15:0];
                tach_pkg::CFG_HYSTERESIS:     hysteresis_reg     <= cfg_data[15:0];
                tach_pkg::CFG_INVALID_LIMIT:  invalid_limit_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Measure the period of a capture
    always_comb
    begin
        capture_ok = (capture_time > prev_capture_reg)
                     && (countdown_reg == tach_pkg::COUNTDOWN_FULL);
        new_period = capture_time - prev_capture_reg;
        if (new_period < tach_pkg::MIN_PERIOD)
        begin
            new_period = tach_pkg::INVALID_MARK;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tach_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tach_pkg::ST_READ;
                end
            end
            tach_pkg::ST_READ:      state_next = tach_pkg::ST_WRITE;
            tach_pkg::ST_WRITE:     state_next = tach_pkg::ST_AVG_START;
            tach_pkg::ST_AVG_START: state_next = tach_pkg::ST_AVG_WAIT;
            tach_pkg::ST_AVG_WAIT:
            begin
                if (div_status.done)
                begin
                    if ((div_quotient[15:0] > max_avg_period_reg) || stale_reg || ring_bad)
                    begin
                        state_next = tach_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tach_pkg::ST_SPD_START;
                    end
                end
            end
            tach_pkg::ST_SPD_START: state_next = tach_pkg::ST_SPD_WAIT;
            tach_pkg::ST_SPD_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = tach_pkg::ST_DONE;
                end
            end
            tach_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tach_pkg::ST_IDLE;
                end
            end
            default: state_next = tach_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        out_free         = !out_valid_reg || out_ready;
        in_ready         = 1'b0;
        ring_ctrl.load   = 1'b0;
        ring_ctrl.commit = 1'b0;
        div_start        = 1'b0;
        commit           = 1'b0;
        div_dividend     = tach_pkg::DIV_W'(ring_sum) << (tach_pkg::DIV_W - tach_pkg::SUM_W);
        div_divisor      = tach_pkg::DIVISOR_W'(tach_pkg::RING_DEPTH);
        div_steps        = tach_pkg::DIV_CNT_W'(tach_pkg::SUM_W);
        case (state_reg)
            tach_pkg::ST_IDLE:      in_ready         = 1'b1;
            tach_pkg::ST_READ:      ring_ctrl.load   = store_reg;
            tach_pkg::ST_WRITE:     ring_ctrl.commit = store_reg;
            tach_pkg::ST_AVG_START: div_start        = 1'b1;
            tach_pkg::ST_SPD_START:
            begin
                div_start    = 1'b1;
                div_dividend = speed_constant_reg;
                div_divisor  = avg_reg;
                div_steps    = tach_pkg::DIV_CNT_W'(tach_pkg::DIV_W);
            end
            tach_pkg::ST_DONE:      commit           = out_free;
            default:
            begin
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // Decide speed, invalid count and relays for this item
    always_comb
    begin
        // A zero divisor gives an all-ones quotient, which saturates as well
        speed_sat          = (div_quotient[23:16] != 8'd0) ? tach_pkg::SPEED_MAX
                                                           : div_quotient[15:0];
        count_inc          = invalid_count_reg + 8'd1;
        held_speed_next    = held_speed_reg;
        invalid_count_next = invalid_count_reg;
        if ((avg_reg > max_avg_period_reg) || stale_reg)
        begin
            held_speed_next = 16'd0;
        end
        else if (!ring_bad)
        begin
            held_speed_next    = speed_sat;
            invalid_count_next = 8'd0;
        end
        else
        begin
            invalid_count_next = count_inc;
            if (count_inc >= invalid_limit_reg)
            begin
                held_speed_next = 16'd0;
                if (count_inc >= tach_pkg::WRAP_AT)
                begin
                    invalid_count_next = tach_pkg::WRAP_TO;
                end
            end
        end
        levels[0] = level_low_reg;
        levels[1] = level_mid_reg;
        levels[2] = level_high_reg;
        for (int i = 0; i < 3; i++)
        begin
            relay_next[i] = (held_speed_next >= levels[i])
                            || (relay_reg[i]
                                && !(({1'b0, held_speed_next} + {1'b0, hysteresis_reg})
                                     < {1'b0, levels[i]}));
        end
    end

    // Advance state and capture per-item data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tach_pkg::ST_IDLE;
            prev_capture_reg  <= 16'd0;
            countdown_reg     <= 5'd0;
            stale_reg         <= 1'b0;
            store_reg         <= 1'b0;
            invalid_count_reg <= 8'd0;
            held_speed_reg    <= 16'd0;
            relay_reg         <= 3'b000;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (cmd == tach_pkg::CMD_CAPTURE)
                begin
                    store_reg        <= capture_ok;
                    prev_capture_reg <= capture_time;
                    countdown_reg    <= tach_pkg::COUNTDOWN_FULL;
                    stale_reg        <= 1'b0;
                end
                else
                begin
                    store_reg <= 1'b0;
                    if (countdown_reg != 5'd0)
                    begin
                        countdown_reg <= countdown_reg - 5'd1;
                    end
                    else
                    begin
                        stale_reg <= 1'b1;
                    end
                end
            end
            if (commit)
            begin
                invalid_count_reg <= invalid_count_next;
                held_speed_reg    <= held_speed_next;
                relay_reg         <= relay_next;
            end
        end
    end

    // Hold period and average
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            period_reg <= new_period;
        end
        if ((state_reg == tach_pkg::ST_AVG_WAIT) && div_status.done)
        begin
            avg_reg <= div_quotient[15:0];
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            speed_reg        <= held_speed_next;
            relay_out_reg    <= relay_next;
            ring_invalid_reg <= ring_bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign speed        = speed_reg;
    assign relay_low    = relay_out_reg[0];
    assign relay_mid    = relay_out_reg[1];
    assign relay_high   = relay_out_reg[2];
    assign ring_invalid = ring_invalid_reg;

    // A new result appears only when the sequencer finishes an item
    `TACH_ASSERT(a_out_from_done, !$rose(out_valid_reg) || ($past(state_reg) == tach_pkg::ST_DONE), "result raised outside done state")
    // The divider is never running while the block waits for an item
    `TACH_ASSERT(a_div_idle, !((state_reg == tach_pkg::ST_IDLE) && div_status.busy), "divider busy while idle")
    // A finished result is never overwritten before it is taken
    `TACH_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg && $stable(speed_reg), "pending result lost")

endmodule

// File: rtl/tach_ring.sv
// ----------------------------------------------------------------------------
// Period ring
// Holds the last periods in a small memory with per-slot valid bits and keeps
// a running sum and a count of zero or invalid slots.
// ----------------------------------------------------------------------------
module tach_ring (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tach_pkg::ring_ctrl_t      ctrl,
    input  logic [15:0]               wr_data,
    output logic [tach_pkg::SUM_W-1:0] sum,
    output logic                      bad
);

    logic [15:0]                      mem [tach_pkg::RING_DEPTH];
    logic [tach_pkg::RING_DEPTH-1:0]  valid_reg;
    logic [tach_pkg::SLOT_W-1:0]      slot_reg;
    logic [15:0]                      old_reg;
    logic                             old_valid_reg;
    logic [tach_pkg::SUM_W-1:0]       sum_reg;
    logic [tach_pkg::SUM_W-1:0]       sum_next;
    logic [tach_pkg::BAD_W-1:0]       bad_count_reg;
    logic [tach_pkg::BAD_W-1:0]       bad_count_next;
    logic [tach_pkg::SLOT_W-1:0]      slot_next;
    logic [15:0]                      old_value;
    logic                             old_bad;
    logic                             new_bad;

    // Read the slot about to be overwritten
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            old_reg <= mem[slot_reg];
        end
    end

    // Write the new period
    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            mem[slot_reg] <= wr_data;
        end
    end

    // Work out the sum and bad count after replacing the old slot
    always_comb
    begin
        old_value      = old_valid_reg ? old_reg : 16'd0;
        old_bad        = (old_value == 16'd0) || (old_value == tach_pkg::INVALID_MARK);
        new_bad        = (wr_data == 16'd0) || (wr_data == tach_pkg::INVALID_MARK);
        sum_next       = sum_reg - tach_pkg::SUM_W'(old_value)
                         + tach_pkg::SUM_W'(wr_data);
        bad_count_next = bad_count_reg - tach_pkg::BAD_W'(old_bad)
                         + tach_pkg::BAD_W'(new_bad);
        if (slot_reg == '0)
        begin
            slot_next = tach_pkg::SLOT_W'(tach_pkg::RING_DEPTH - 1);
        end
        else
        begin
            slot_next = slot_reg - 1'b1;
        end
    end

    // Hold valid bits, slot pointer and running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            slot_reg      <= tach_pkg::SLOT_W'(tach_pkg::RING_DEPTH - 1);
            old_valid_reg <= 1'b0;
            sum_reg       <= '0;
            bad_count_reg <= tach_pkg::BAD_W'(tach_pkg::RING_DEPTH);
        end
        else
        begin
            if (ctrl.load)
            begin
                old_valid_reg <= valid_reg[slot_reg];
            end
            if (ctrl.commit)
            begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg            <= slot_next;
                sum_reg             <= sum_next;
                bad_count_reg       <= bad_count_next;
            end
        end
    end

    assign sum = sum_reg;
    assign bad = (bad_count_reg != '0);

endmodule

// File: rtl/tach_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that shifts the dividend in one bit per cycle and
// produces one quotient bit per cycle, for a chosen number of steps.
// ----------------------------------------------------------------------------
module tach_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tach_pkg::DIV_W-1:0]      dividend,
    input  logic [tach_pkg::DIVISOR_W-1:0]  divisor,
    input  logic [tach_pkg::DIV_CNT_W-1:0]  steps,
    output tach_pkg::div_status_t           status,
    output logic [tach_pkg::DIV_W-1:0]      quotient
);

    logic [tach_pkg::DIV_W-1:0]      dvd_reg;
    logic [tach_pkg::DIVISOR_W-1:0]  dvs_reg;
    logic [tach_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [tach_pkg::DIV_W-1:0]      quot_reg;
    logic [tach_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [tach_pkg::DIVISOR_W:0]    trial;
    logic                            fits;

    // Bring down the next dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, dvd_reg[tach_pkg::DIV_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Shift datapath, one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[tach_pkg::DIV_W-2:0], 1'b0};
            quot_reg <= {quot_reg[tach_pkg::DIV_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= tach_pkg::DIVISOR_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= tach_pkg::DIVISOR_W'(trial);
            end
        end
    end

    // Count steps and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tach_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;

endmodule

// File: bench/tb_engine_speed_tachometer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Engine speed tachometer testbench
// Feeds capture and overflow events through the valid/ready input, tracks the
// period ring, timer watchdog, invalid counter and relays in a local model,
// and compares every speed reading with the model's prediction while both
// sides idle and stall at random and the registers move through several
// settings.
// ----------------------------------------------------------------------------
module tb_engine_speed_tachometer_top;
    import tach_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int          RESET_LEN   = 9;
    localparam int          HOLD_CYCLES = 600;
    localparam int          TAIL_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // Index past the end of the register file, must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [15:0] speed;
        logic        relay_low;
        logic        relay_mid;
        logic        relay_high;
        logic        ring_invalid;
    } speed_reading_t;

    // ------------------------------------------------------------------------
    // Speed tracker: local model of the tachometer plus readings in flight
    // ------------------------------------------------------------------------
    class speed_tracker;
        logic [23:0]      rpm_dividend;
        logic [15:0]      avg_ceiling;
        logic [15:0]      relay_set [3];
        logic [15:0]      relay_band;
        logic [7:0]       bad_eval_limit;

        logic [15:0]      period_slots [RING_DEPTH];
        int               write_slot;
        logic [15:0]      last_stamp;
        logic [4:0]       ovf_budget;
        logic             timer_dead;
        logic [7:0]       bad_evals;
        logic [15:0]      rpm_hold;
        logic [2:0]       relay_state;

        speed_reading_t   pending_readings [$];
        int unsigned      n_items, n_checked, n_errors;
        int unsigned      n_stored, n_zeroed, n_held, n_wraps, n_saturated;

        function new();
            rpm_dividend   = RST_SPEED_CONSTANT;
            avg_ceiling    = RST_MAX_AVG_PERIOD;
            relay_set[0]   = RST_LEVEL_LOW;
            relay_set[1]   = RST_LEVEL_MID;
            relay_set[2]   = RST_LEVEL_HIGH;
            relay_band     = RST_HYSTERESIS;
            bad_eval_limit = RST_INVALID_LIMIT;
            foreach (period_slots[i])
                period_slots[i] = '0;
            write_slot  = RING_DEPTH - 1;
            last_stamp  = '0;
            ovf_budget  = '0;
            timer_dead  = 1'b0;
            bad_evals   = '0;
            rpm_hold    = '0;
            relay_state = '0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SPEED_CONSTANT: rpm_dividend   = data[23:0];
                CFG_MAX_AVG_PERIOD: avg_ceiling    = data[15:0];
                CFG_LEVEL_LOW:      relay_set[0]   = data[15:0];
                CFG_LEVEL_MID:      relay_set[1]   = data[15:0];
                CFG_LEVEL_HIGH:     relay_set[2]   = data[15:0];
                CFG_HYSTERESIS:     relay_band     = data[15:0];
                CFG_INVALID_LIMIT:  bad_eval_limit = data[7:0];
                default: ;
            endcase
        endfunction

        // Advance the model by one accepted event and queue the reading it gives
        function void take_item(logic kind, logic [15:0] stamp_in);
            logic [15:0]      period;
            logic [SUM_W-1:0] ring_sum;
            logic [15:0]      average;
            logic [23:0]      quotient;
            logic             ring_bad;
            int               k;
            speed_reading_t   reading;
            ring_sum = '0;
            ring_bad = 1'b0;
            n_items++;

            // Store the period only with a full watchdog and a rising timestamp
            if (kind == CMD_CAPTURE)
            begin
                if (stamp_in > last_stamp && ovf_budget == COUNTDOWN_FULL)
                begin
                    period = stamp_in - last_stamp;
                    if (period < MIN_PERIOD)
                        period = INVALID_MARK;
                    period_slots[write_slot] = period;
                    write_slot = (write_slot == 0) ? RING_DEPTH - 1 : write_slot - 1;
                    n_stored++;
                end
                last_stamp = stamp_in;
                ovf_budget = COUNTDOWN_FULL;
                timer_dead = 1'b0;
            end
            else if (ovf_budget != 0)
                ovf_budget = ovf_budget - 1'b1;
            else
                timer_dead = 1'b1;

            foreach (period_slots[i])
            begin
                if (period_slots[i] == INVALID_MARK || period_slots[i] == '0)
                    ring_bad = 1'b1;
                ring_sum = ring_sum + SUM_W'(period_slots[i]);
            end
            average = 16'(ring_sum / RING_DEPTH);

            // Zero on a dead timer or slow average, hold on a bad ring until the invalid count reaches its limit
            if (average > avg_ceiling || timer_dead)
            begin
                rpm_hold = '0;
                n_zeroed++;
            end
            else if (!ring_bad)
            begin
                quotient = (average == '0) ? 24'(SPEED_MAX) : rpm_dividend / 24'(average);
                if (quotient >= 24'(SPEED_MAX))
                    n_saturated++;
                rpm_hold  = (quotient > 24'(SPEED_MAX)) ? SPEED_MAX : quotient[15:0];
                bad_evals = '0;
            end
            else
            begin
                bad_evals = bad_evals + 8'd1;
                if (bad_evals >= bad_eval_limit)
                begin
                    if (bad_evals >= WRAP_AT)
                    begin
                        bad_evals = WRAP_TO;
                        n_wraps++;
                    end
                    rpm_hold = '0;
                end
                else
                    n_held++;
            end

            // Set at the level, clear below level minus the band
            for (k = 0; k < 3; k++)
            begin
                if (rpm_hold >= relay_set[k])
                    relay_state[k] = 1'b1;
                if ({1'b0, rpm_hold} + {1'b0, relay_band} < {1'b0, relay_set[k]})
                    relay_state[k] = 1'b0;
            end

            reading.speed        = rpm_hold;
            reading.relay_low    = relay_state[0];
            reading.relay_mid    = relay_state[1];
            reading.relay_high   = relay_state[2];
            reading.ring_invalid = ring_bad;
            pending_readings.push_back(reading);
        endfunction

        task flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
            n_errors++;
            $display("[%0t] mismatch on reading %0d: %s got %0d, expected %0d",
                     $time, n_checked, what, got, want);
        endtask

        // Compare one accepted reading with the oldest prediction
        task match_reading(speed_reading_t seen);
            speed_reading_t want;
            if (pending_readings.size() == 0)
            begin
                flag_mismatch("reading with no event pending, speed", seen.speed, '0);
                return;
            end
            want = pending_readings.pop_front();
            if (seen.speed !== want.speed)
                flag_mismatch("speed", seen.speed, want.speed);
            if (seen.relay_low !== want.relay_low)
                flag_mismatch("relay_low", 16'(seen.relay_low), 16'(want.relay_low));
            if (seen.relay_mid !== want.relay_mid)
                flag_mismatch("relay_mid", 16'(seen.relay_mid), 16'(want.relay_mid));
            if (seen.relay_high !== want.relay_high)
                flag_mismatch("relay_high", 16'(seen.relay_high), 16'(want.relay_high));
            if (seen.ring_invalid !== want.ring_invalid)
                flag_mismatch("ring_invalid", 16'(seen.ring_invalid),
                              16'(want.ring_invalid));
            n_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic                   cmd          = CMD_CAPTURE;
    logic [15:0]            capture_time = '0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [15:0]            speed;
    logic                   relay_low;
    logic                   relay_mid;
    logic                   relay_high;
    logic                   ring_invalid;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = CFG_SPEED_CONSTANT;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    speed_tracker tracker = new();

    logic [15:0] stamp        = '0;
    int          burst_left   = 0;
    int unsigned n_sent       = 0;
    int unsigned n_settings   = 1;
    int unsigned cycle_count  = 0;
    bit          hold_request = 1'b0;

    engine_speed_tachometer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .capture_time (capture_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .speed        (speed),
        .relay_low    (relay_low),
        .relay_mid    (relay_mid),
        .relay_high   (relay_high),
        .ring_invalid (ring_invalid),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offer one event in bursts with random gaps between them
    task automatic send_event(input logic kind, input logic [15:0] stamp_in);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid     <= 1'b1;
        cmd          <= kind;
        capture_time <= stamp_in;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        tracker.take_item(kind, stamp_in);
        burst_left--;
        n_sent++;
    endtask

    // Drop valid and wait until every reading is back
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        while (tracker.pending_readings.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Fill bits above a register's width with noise
    function automatic logic [CFG_DATA_W-1:0] pad_high(logic [CFG_DATA_W-1:0] v, int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom());
        return (junk << w) | v;
    endfunction

    // Write all registers while idle, optionally poking the unused index first
    task automatic load_config(input logic [CFG_DATA_W-1:0] dividend, ceiling,
                               input logic [CFG_DATA_W-1:0] lvl_low, lvl_mid, lvl_high,
                               input logic [CFG_DATA_W-1:0] band, limit,
                               input bit poke_unused);
        logic [CFG_INDEX_W-1:0] reg_idx [8];
        logic [CFG_DATA_W-1:0]  word [8];
        int                     n;
        reg_idx = '{CFG_UNUSED, CFG_SPEED_CONSTANT, CFG_MAX_AVG_PERIOD, CFG_LEVEL_LOW,
                    CFG_LEVEL_MID, CFG_LEVEL_HIGH, CFG_HYSTERESIS, CFG_INVALID_LIMIT};
        word    = '{CFG_DATA_W'($urandom()), dividend, ceiling, lvl_low, lvl_mid, lvl_high,
                    band, limit};
        settle(4);
        for (n = poke_unused ? 0 : 1; n < 8; n++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_idx[n];
            cfg_data  <= word[n];
            @(posedge clk);
            tracker.set_reg(reg_idx[n], word[n]);
        end
        cfg_we <= 1'b0;
        burst_left = 0;
        n_settings++;
    endtask

    // Mostly steady engine runs, plus ticks, short periods, rejects and noise
    task automatic run_random(input int count, input bit squeeze);
        int unsigned goal;
        int          kind, len, base, step, j;
        bit          held_off;
        logic [31:0] noise;
        goal     = n_sent + count;
        held_off = 1'b0;
        while (n_sent < goal)
        begin
            if (squeeze && !held_off && n_sent + 2 * count / 3 >= goal)
            begin
                hold_request = 1'b1;
                held_off     = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // Steady engine with a drifting period
                case ($urandom_range(0, 9))
                    0:       base = $urandom_range(100, 400);
                    1, 2:    base = $urandom_range(400, 3000);
                    3, 4, 5: base = $urandom_range(3000, 8000);
                    6, 7:    base = $urandom_range(8000, 20000);
                    8:       base = $urandom_range(20000, 40000);
                    default: base = $urandom_range(60, 160);
                endcase
                len = $urandom_range(18, 60);
                for (j = 0; j < len; j++)
                begin
                    if ($urandom_range(0, 23) == 0)
                        send_event(CMD_OVERFLOW, 16'($urandom()));
                    else
                    begin
                        step = base / 16 + 1;
                        base = base + int'($urandom_range(0, 2 * step)) - step;
                        if (base < 60)
                            base = 60;
                        if (base > 65535)
                            base = 65535;
                        stamp = stamp + base[15:0];
                        send_event(CMD_CAPTURE, stamp);
                    end
                end
            end
            else if (kind < 65)
            begin
                // Run of overflow ticks, long enough at times to kill the timer
                len = $urandom_range(1, 24);
                repeat (len) send_event(CMD_OVERFLOW, 16'($urandom()));
            end
            else if (kind < 75)
            begin
                // Periods around the minimum
                len = $urandom_range(4, 16);
                repeat (len)
                begin
                    stamp = stamp + 16'($urandom_range(1, 150));
                    send_event(CMD_CAPTURE, stamp);
                end
            end
            else if (kind < 82)
            begin
                // Equal or falling timestamps
                len = $urandom_range(3, 30);
                repeat (len)
                begin
                    stamp = stamp - 16'($urandom_range(0, 2000));
                    send_event(CMD_CAPTURE, stamp);
                end
            end
            else
            begin
                len = $urandom_range(4, 16);
                repeat (len)
                begin
                    noise = $urandom();
                    if (noise[16])
                        send_event(CMD_OVERFLOW, noise[15:0]);
                    else
                    begin
                        stamp = noise[15:0];
                        send_event(CMD_CAPTURE, stamp);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall on shifting patterns, hold off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int mode      = 0;
        int mode_left = 0;
        int hold_left = 0;
        int beat      = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.match_reading({speed, relay_low, relay_mid, relay_high, ring_invalid});
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            beat++;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (beat % 5 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d readings outstanding",
                 cycle_count, tracker.pending_readings.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dead timer, first capture, full-scale and short periods
        send_event(CMD_OVERFLOW, 16'hffff);
        send_event(CMD_CAPTURE, 16'd0);
        send_event(CMD_CAPTURE, 16'hffff);
        send_event(CMD_CAPTURE, 16'hffff);
        send_event(CMD_CAPTURE, 16'd199);
        send_event(CMD_CAPTURE, 16'd298);
        send_event(CMD_CAPTURE, 16'd398);
        // A tick between captures voids the period
        send_event(CMD_OVERFLOW, 16'd0);
        send_event(CMD_CAPTURE, 16'd1000);
        // Run the watchdog out until the timer goes stale
        repeat (17) send_event(CMD_OVERFLOW, 16'($urandom()));
        stamp = 16'd1400;
        send_event(CMD_CAPTURE, stamp);

        // Reset settings, with a long receiver hold-off
        run_random(200, 1'b1);

        // Park an invalid mark and keep the ring bad until the counter wraps
        stamp = 16'($urandom_range(0, 60000));
        send_event(CMD_CAPTURE, stamp);
        stamp = stamp + 16'd1;
        send_event(CMD_CAPTURE, stamp);
        repeat (255) send_event(CMD_CAPTURE, stamp);

        // Extremes: saturating dividend, widest window, zero band
        load_config(24'hffffff, 24'hffff, 24'd0, 24'd1000, 24'hffff, 24'd0, 24'd255, 1'b1);
        run_random(200, 1'b0);

        // Extremes: smallest dividend and window, band wider than levels
        load_config(24'd1, 24'd1, 24'hffff, 24'd0, 24'd100, 24'hffff, 24'd1, 1'b0);
        run_random(100, 1'b0);

        // Random settings with noise above each register's width
        repeat (2)
        begin
            load_config(CFG_DATA_W'($urandom_range(100000, 24'hffffff)),
                        pad_high(CFG_DATA_W'($urandom_range(1000, 65535)), 16),
                        pad_high(CFG_DATA_W'($urandom_range(0, 3000)), 16),
                        pad_high(CFG_DATA_W'($urandom_range(0, 8000)), 16),
                        pad_high(CFG_DATA_W'($urandom_range(0, 20000)), 16),
                        pad_high(CFG_DATA_W'($urandom_range(0, 2000)), 16),
                        pad_high(CFG_DATA_W'($urandom_range(1, 255)), 8), 1'b1);
            run_random(150, 1'b0);
        end

        // Back to the reset values, written explicitly
        load_config(CFG_DATA_W'(RST_SPEED_CONSTANT), CFG_DATA_W'(RST_MAX_AVG_PERIOD),
                    CFG_DATA_W'(RST_LEVEL_LOW), CFG_DATA_W'(RST_LEVEL_MID),
                    CFG_DATA_W'(RST_LEVEL_HIGH), CFG_DATA_W'(RST_HYSTERESIS),
                    CFG_DATA_W'(RST_INVALID_LIMIT), 1'b0);
        run_random(150, 1'b0);

        settle(TAIL_CYCLES);

        $display("run covered %0d events over %0d register settings: %0d periods stored, %0d saturated",
                 tracker.n_items, n_settings, tracker.n_stored, tracker.n_saturated);
        $display("%0d zeroed by dead timer or slow average, %0d held, %0d counter wraps, %0d readings checked",
                 tracker.n_zeroed, tracker.n_held, tracker.n_wraps, tracker.n_checked);
        if (tracker.n_errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tach_pkg.sv
rtl/tach_ring.sv
rtl/tach_div.sv
rtl/engine_speed_tachometer_top.sv
bench/tb_engine_speed_tachometer_top.sv
